### src/assert_macros.svh
// assertion helpers shared by the rtl files
// every property is sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PDLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PDLL_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PDLL_ASSERT(lbl, prop, msg)
`define PDLL_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### src/pdll_pkg.sv
package pdll_pkg;

  // fixed beat field widths
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned POS_IN_W  = 9;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STS_W     = 3;
  localparam int unsigned POS_OUT_W = 8;
  localparam int unsigned CNT_OUT_W = 9;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_FIND      = 3'd6,
    REQ_READ_AT   = 3'd7
  } req_e;

  // response status codes
  typedef enum logic [STS_W-1:0] {
    STS_OK        = 3'd0,
    STS_BAD_POS   = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_FULL      = 3'd3,
    STS_NOT_FOUND = 3'd4
  } sts_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREE_RD,
    ST_FREE_WB,
    ST_WALK,
    ST_FIND,
    ST_NODE_RD,
    ST_NODE_WB,
    ST_LINK1,
    ST_LINK2,
    ST_DEL1,
    ST_DEL2,
    ST_DONE
  } state_e;

endpackage

### src/pdll_if.sv
// request channel
interface pdll_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [pdll_pkg::REQ_W-1:0]           req_type;
  logic [pdll_pkg::POS_IN_W-1:0]        position_in;
  logic signed [pdll_pkg::DATA_W-1:0]   data_in;

  modport source (output valid, req_type, position_in, data_in, input ready);
  modport sink   (input valid, req_type, position_in, data_in, output ready);
endinterface

// response channel
interface pdll_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [pdll_pkg::STS_W-1:0]           status;
  logic signed [pdll_pkg::DATA_W-1:0]   data_out;
  logic [pdll_pkg::POS_OUT_W-1:0]       position_out;
  logic [pdll_pkg::CNT_OUT_W-1:0]       count_out;

  modport source (output valid, status, data_out, position_out, count_out, input ready);
  modport sink   (input valid, status, data_out, position_out, count_out, output ready);
endinterface

### src/pooled_doubly_linked_list_core.sv
// Doubly linked list kept in a pool of POOL_DEPTH nodes, with a free chain.
// req_i takes one request beat: insert front/back/at position, delete
// front/back/at position, find a value or read at a position. rsp_o gives
// one beat per request: status, removed or read value, found position and
// the list length after the request.
// Requests are handled one at a time by a small sequencer over three pool
// memories (value, next link, prev link) with registered reads. A request
// at a position walks the list from the head through the next-link memory,
// and a search compares one node after another.
// req_i.ready is high while the sequencer is idle; a finished response
// sits in the output register, so a new request is taken while the
// receiver stalls, and the next response waits until the register frees.
// Reset empties the list and makes every node free at once: untouched nodes
// are tracked by a fill mark, so there is no clearing pass.
`include "assert_macros.svh"

module pooled_doubly_linked_list_core #(
  parameter int unsigned POOL_DEPTH  = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pdll_req_if.sink   req_i,
  pdll_rsp_if.source rsp_o
);

  localparam int unsigned AW   = $clog2(POOL_DEPTH);
  localparam int unsigned PW   = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CMPW = (PW > pdll_pkg::POS_IN_W) ? PW : pdll_pkg::POS_IN_W;
  localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

  function automatic logic is_node(logic [PW-1:0] p);
    return p < NIL;
  endfunction

  function automatic logic is_ins(pdll_pkg::req_e r);
    return (r == pdll_pkg::REQ_INS_FRONT) || (r == pdll_pkg::REQ_INS_BACK) ||
           (r == pdll_pkg::REQ_INS_AT);
  endfunction

  // control state
  pdll_pkg::state_e state_q, state_d;
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [PW-1:0] free_q, free_d;
  logic [PW-1:0] count_q, count_d;
  logic [PW-1:0] hwm_q, hwm_d;
  logic          out_valid_q, out_valid_d;

  // per-request working registers
  pdll_pkg::req_e        req_q, req_d;
  pdll_pkg::sts_e        sts_q, sts_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic [PW-1:0]         cur_q, cur_d;
  logic [PW-1:0]         prv_q, prv_d;
  logic [PW-1:0]         nx_q, nx_d;
  logic [PW-1:0]         newfree_q, newfree_d;
  logic [PW-1:0]         rem_q, rem_d;
  logic [PW-1:0]         idx_q, idx_d;
  logic                  pend_q, pend_d;
  logic signed [VALUE_WIDTH-1:0] res_val_q, res_val_d;

  // response register payload
  logic [pdll_pkg::STS_W-1:0]         out_sts_q, out_sts_d;
  logic signed [pdll_pkg::DATA_W-1:0] out_data_q, out_data_d;
  logic [pdll_pkg::POS_OUT_W-1:0]     out_pos_q, out_pos_d;
  logic [pdll_pkg::CNT_OUT_W-1:0]     out_cnt_q, out_cnt_d;

  // pool memory ports
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] val_rdata;
  logic [PW-1:0]          next_rdata;
  logic [PW-1:0]          prev_rdata;
  logic                   val_we, next_we, prev_we;
  logic [AW-1:0]          val_waddr, next_waddr, prev_waddr;
  logic [VALUE_WIDTH-1:0] val_wdata;
  logic [PW-1:0]          next_wdata, prev_wdata;

  // request decode
  pdll_pkg::req_e  req_t;
  pdll_pkg::sts_e  acc_sts;
  logic            acc_done;
  logic [PW-1:0]   acc_cur, acc_prv, acc_rem;
  logic [CMPW-1:0] cnt_w, pos_w;
  logic            accept;
  logic signed [63:0] din_ext;

  // walk and search helpers
  logic            hit, last;
  logic            out_free;
  logic signed [63:0] res_ext;
  logic [CMPW-1:0] cnt_ext, idx_ext;

  assign req_i.ready = (state_q == pdll_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign req_t       = pdll_pkg::req_e'(req_i.req_type);
  assign din_ext     = 64'(req_i.data_in);
  assign cnt_w       = CMPW'(count_q);
  assign pos_w       = CMPW'(req_i.position_in);
  assign hit         = (val_rdata == key_q);
  assign last        = (PW'(idx_q + PW'(1)) == count_q);
  assign out_free    = !out_valid_q || rsp_o.ready;

  // pool memories
  pdll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  pdll_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (rd_addr),
    .rdata_o (next_rdata)
  );

  pdll_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prev_rdata)
  );

  // request checks and walk setup
  always_comb begin
    acc_sts  = pdll_pkg::STS_OK;
    acc_done = 1'b0;
    acc_cur  = head_q;
    acc_prv  = NIL;
    acc_rem  = '0;
    case (req_t)
      pdll_pkg::REQ_INS_FRONT, pdll_pkg::REQ_INS_BACK, pdll_pkg::REQ_INS_AT: begin
        if (!is_node(free_q)) begin
          acc_sts  = pdll_pkg::STS_FULL;
          acc_done = 1'b1;
        end else if (count_q == '0) begin
          acc_cur = NIL;
        end else if (req_t == pdll_pkg::REQ_INS_BACK) begin
          acc_cur = NIL;
          acc_prv = tail_q;
        end else if (req_t == pdll_pkg::REQ_INS_AT) begin
          if (pos_w > cnt_w) begin
            acc_sts  = pdll_pkg::STS_BAD_POS;
            acc_done = 1'b1;
          end else begin
            acc_rem = PW'(pos_w);
          end
        end
      end
      pdll_pkg::REQ_FIND: begin
        acc_sts = pdll_pkg::STS_NOT_FOUND;
        if (count_q == '0) begin
          acc_done = 1'b1;
        end
      end
      default: begin
        if (count_q == '0) begin
          acc_sts  = pdll_pkg::STS_EMPTY;
          acc_done = 1'b1;
        end else if (req_t == pdll_pkg::REQ_DEL_BACK) begin
          acc_cur = tail_q;
        end else if (req_t == pdll_pkg::REQ_DEL_AT || req_t == pdll_pkg::REQ_READ_AT) begin
          if (pos_w >= cnt_w) begin
            acc_sts  = pdll_pkg::STS_BAD_POS;
            acc_done = 1'b1;
          end else begin
            acc_rem = PW'(pos_w);
          end
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pdll_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          if (acc_done) begin
            state_d = pdll_pkg::ST_DONE;
          end else if (is_ins(req_t)) begin
            state_d = pdll_pkg::ST_FREE_RD;
          end else if (req_t == pdll_pkg::REQ_FIND) begin
            state_d = pdll_pkg::ST_FIND;
          end else if (acc_rem == '0) begin
            state_d = pdll_pkg::ST_NODE_RD;
          end else begin
            state_d = pdll_pkg::ST_WALK;
          end
        end
      end
      pdll_pkg::ST_FREE_RD: state_d = pdll_pkg::ST_FREE_WB;
      pdll_pkg::ST_FREE_WB: begin
        state_d = (rem_q == '0) ? pdll_pkg::ST_LINK1 : pdll_pkg::ST_WALK;
      end
      pdll_pkg::ST_WALK: begin
        if (pend_q && rem_q == PW'(1)) begin
          state_d = is_ins(req_q) ? pdll_pkg::ST_LINK1 : pdll_pkg::ST_NODE_RD;
        end
      end
      pdll_pkg::ST_FIND: begin
        if (pend_q && (hit || last)) begin
          state_d = pdll_pkg::ST_DONE;
        end
      end
      pdll_pkg::ST_NODE_RD: state_d = pdll_pkg::ST_NODE_WB;
      pdll_pkg::ST_NODE_WB: begin
        state_d = (req_q == pdll_pkg::REQ_READ_AT) ? pdll_pkg::ST_DONE : pdll_pkg::ST_DEL1;
      end
      pdll_pkg::ST_LINK1: state_d = pdll_pkg::ST_LINK2;
      pdll_pkg::ST_LINK2: state_d = pdll_pkg::ST_DONE;
      pdll_pkg::ST_DEL1:  state_d = pdll_pkg::ST_DEL2;
      pdll_pkg::ST_DEL2:  state_d = pdll_pkg::ST_DONE;
      pdll_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = pdll_pkg::ST_IDLE;
        end
      end
      default: state_d = pdll_pkg::ST_IDLE;
    endcase
  end

  // pool memory control
  always_comb begin
    rd_addr    = cur_q[AW-1:0];
    val_we     = 1'b0;
    val_waddr  = free_q[AW-1:0];
    val_wdata  = key_q;
    next_we    = 1'b0;
    next_waddr = free_q[AW-1:0];
    next_wdata = cur_q;
    prev_we    = 1'b0;
    prev_waddr = free_q[AW-1:0];
    prev_wdata = prv_q;
    case (state_q)
      pdll_pkg::ST_FREE_RD: rd_addr = free_q[AW-1:0];
      pdll_pkg::ST_WALK, pdll_pkg::ST_FIND: begin
        if (pend_q) begin
          rd_addr = next_rdata[AW-1:0];
        end
      end
      // new node gets its value and both links
      pdll_pkg::ST_LINK1: begin
        val_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      // neighbors point at the new node
      pdll_pkg::ST_LINK2: begin
        next_we    = is_node(prv_q);
        next_waddr = prv_q[AW-1:0];
        next_wdata = free_q;
        prev_we    = is_node(cur_q);
        prev_waddr = cur_q[AW-1:0];
        prev_wdata = free_q;
      end
      // neighbors bypass the removed node
      pdll_pkg::ST_DEL1: begin
        next_we    = is_node(prv_q);
        next_waddr = prv_q[AW-1:0];
        next_wdata = nx_q;
        prev_we    = is_node(nx_q);
        prev_waddr = nx_q[AW-1:0];
        prev_wdata = prv_q;
      end
      // removed node goes to the front of the free chain
      pdll_pkg::ST_DEL2: begin
        next_we    = 1'b1;
        next_waddr = cur_q[AW-1:0];
        next_wdata = free_q;
        prev_we    = 1'b1;
        prev_waddr = cur_q[AW-1:0];
        prev_wdata = NIL;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    free_d    = free_q;
    count_d   = count_q;
    hwm_d     = hwm_q;
    req_d     = req_q;
    sts_d     = sts_q;
    key_d     = key_q;
    cur_d     = cur_q;
    prv_d     = prv_q;
    nx_d      = nx_q;
    newfree_d = newfree_q;
    rem_d     = rem_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    res_val_d = res_val_q;
    case (state_q)
      pdll_pkg::ST_IDLE: begin
        if (accept) begin
          req_d     = req_t;
          sts_d     = acc_sts;
          key_d     = din_ext[VALUE_WIDTH-1:0];
          cur_d     = acc_cur;
          prv_d     = acc_prv;
          rem_d     = acc_rem;
          idx_d     = '0;
          pend_d    = 1'b0;
          res_val_d = '0;
        end
      end
      // nodes at or above the fill mark were never linked and chain in order
      pdll_pkg::ST_FREE_WB: begin
        newfree_d = (free_q >= hwm_q) ? PW'(free_q + PW'(1)) : next_rdata;
      end
      pdll_pkg::ST_WALK: begin
        if (!pend_q) begin
          pend_d = 1'b1;
        end else begin
          prv_d = cur_q;
          cur_d = next_rdata;
          rem_d = PW'(rem_q - PW'(1));
          if (rem_q == PW'(1)) begin
            pend_d = 1'b0;
          end
        end
      end
      pdll_pkg::ST_FIND: begin
        if (!pend_q) begin
          pend_d = 1'b1;
        end else if (hit) begin
          sts_d = pdll_pkg::STS_OK;
        end else if (!last) begin
          idx_d = PW'(idx_q + PW'(1));
          cur_d = next_rdata;
        end
      end
      pdll_pkg::ST_NODE_WB: begin
        res_val_d = val_rdata;
        prv_d     = prev_rdata;
        nx_d      = next_rdata;
      end
      pdll_pkg::ST_LINK2: begin
        if (!is_node(prv_q)) begin
          head_d = free_q;
        end
        if (!is_node(cur_q)) begin
          tail_d = free_q;
        end
        if (free_q >= hwm_q) begin
          hwm_d = PW'(hwm_q + PW'(1));
        end
        free_d  = newfree_q;
        count_d = PW'(count_q + PW'(1));
      end
      pdll_pkg::ST_DEL1: begin
        if (!is_node(prv_q)) begin
          head_d = nx_q;
        end
        if (!is_node(nx_q) && is_node(prv_q)) begin
          tail_d = prv_q;
        end
      end
      pdll_pkg::ST_DEL2: begin
        free_d  = cur_q;
        count_d = PW'(count_q - PW'(1));
      end
      default: ;
    endcase
  end

  // response register
  assign res_ext = 64'(res_val_q);
  assign cnt_ext = CMPW'(count_q);
  assign idx_ext = CMPW'(idx_q);

  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_sts_d   = out_sts_q;
    out_data_d  = out_data_q;
    out_pos_d   = out_pos_q;
    out_cnt_d   = out_cnt_q;
    if (state_q == pdll_pkg::ST_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_sts_d   = sts_q;
      out_data_d  = res_ext[pdll_pkg::DATA_W-1:0];
      out_pos_d   = (sts_q == pdll_pkg::STS_OK) ? idx_ext[pdll_pkg::POS_OUT_W-1:0] : '0;
      out_cnt_d   = cnt_ext[pdll_pkg::CNT_OUT_W-1:0];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_sts_q;
  assign rsp_o.data_out     = out_data_q;
  assign rsp_o.position_out = out_pos_q;
  assign rsp_o.count_out    = out_cnt_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pdll_pkg::ST_IDLE;
      head_q      <= NIL;
      tail_q      <= '0;
      free_q      <= '0;
      count_q     <= '0;
      hwm_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      count_q     <= count_d;
      hwm_q       <= hwm_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    sts_q      <= sts_d;
    key_q      <= key_d;
    cur_q      <= cur_d;
    prv_q      <= prv_d;
    nx_q       <= nx_d;
    newfree_q  <= newfree_d;
    rem_q      <= rem_d;
    idx_q      <= idx_d;
    res_val_q  <= res_val_d;
    out_sts_q  <= out_sts_d;
    out_data_q <= out_data_d;
    out_pos_q  <= out_pos_d;
    out_cnt_q  <= out_cnt_d;
  end

  // checks
  `PDLL_ASSERT(a_count_range, count_q <= NIL, "entry count above pool depth")
  `PDLL_ASSERT(a_full_no_free, (count_q == NIL) |-> (free_q == NIL), "full pool with free node")
  `PDLL_ASSERT(a_count_update, (count_q != $past(count_q)) |-> ($past(state_q) == pdll_pkg::ST_LINK2 || $past(state_q) == pdll_pkg::ST_DEL2), "count changed outside link update")
  `PDLL_ASSERT(a_fill_mono, hwm_q >= $past(hwm_q), "fill mark moved back")
  `PDLL_ASSERT_NEVER(a_walk_rem, (state_q == pdll_pkg::ST_WALK) && (rem_q == '0), "walk with no steps left")

endmodule

### src/pdll_ram.sv
module pdll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/tb_top.sv
module tb_top;

  localparam int unsigned POOL_SLOTS  = 256;
  localparam logic [8:0]  NO_SLOT     = 9'(POOL_SLOTS);
  localparam int unsigned RANDOM_REQS = 2000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = POOL_SLOTS + 44;

  // mix of requests inside one random stretch
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;

  typedef struct {
    pdll_pkg::req_e                  op;
    logic [pdll_pkg::POS_IN_W-1:0]   pos;
    logic [pdll_pkg::DATA_W-1:0]     value;
    bit                              drain_first;
  } list_req_t;

  typedef struct {
    pdll_pkg::sts_e                  status;
    logic [pdll_pkg::DATA_W-1:0]     data;
    logic [pdll_pkg::POS_OUT_W-1:0]  where;
    logic [pdll_pkg::CNT_OUT_W-1:0]  count;
  } list_answer_t;

  logic clk_i;
  logic rst_ni;

  pdll_req_if req_if ();
  pdll_rsp_if rsp_if ();

  pooled_doubly_linked_list_core #(
    .POOL_DEPTH (POOL_SLOTS),
    .VALUE_WIDTH(pdll_pkg::DATA_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow of the node pool
  logic [pdll_pkg::DATA_W-1:0] slot_val  [POOL_SLOTS];
  logic [8:0]        slot_next [POOL_SLOTS];
  logic [8:0]        slot_prev [POOL_SLOTS];
  logic [8:0]        head_slot;
  logic [8:0]        tail_slot;
  logic [8:0]        free_slot;
  int unsigned       list_len;

  list_req_t    req_backlog[$];
  list_answer_t answer_q[$];
  int unsigned  shadow_len;
  int unsigned  accepted_n;
  int unsigned  total_n;
  int unsigned  hold_at;
  int unsigned  hold_left;
  bit           hold_done;
  int unsigned  quiet_n;
  int unsigned  fail_n;
  logic         req_taken;

  // node at a list position, following next links from the head
  function automatic logic [8:0] walk_slots(int unsigned steps);
    logic [8:0] cur;
    cur = head_slot;
    while (steps != 0 && cur != NO_SLOT) begin
      cur = slot_next[cur];
      steps--;
    end
    return cur;
  endfunction

  // take a node off the free chain and link it in at a position
  function automatic void link_slot(int unsigned at, logic [pdll_pkg::DATA_W-1:0] v);
    logic [8:0] n, pred, succ;
    n = free_slot;
    free_slot = slot_next[n];
    slot_val[n] = v;
    if (list_len == 0 || head_slot == NO_SLOT) begin
      slot_next[n] = NO_SLOT;
      slot_prev[n] = NO_SLOT;
      head_slot = n;
      tail_slot = n;
    end else begin
      if (at == 0) begin
        pred = NO_SLOT;
        succ = head_slot;
      end else begin
        pred = walk_slots(at - 1);
        succ = (pred != NO_SLOT) ? slot_next[pred] : NO_SLOT;
      end
      slot_prev[n] = pred;
      slot_next[n] = succ;
      if (pred != NO_SLOT) slot_next[pred] = n;
      else head_slot = n;
      if (succ != NO_SLOT) slot_prev[succ] = n;
      else tail_slot = n;
    end
    list_len++;
  endfunction

  // unlink the node at a position and return it to the free chain
  function automatic logic [pdll_pkg::DATA_W-1:0] unlink_slot(int unsigned at);
    logic [8:0] n, pv, nx;
    n = walk_slots(at);
    if (n == NO_SLOT) return '0;
    pv = slot_prev[n];
    nx = slot_next[n];
    if (pv != NO_SLOT) slot_next[pv] = nx;
    else head_slot = nx;
    if (nx != NO_SLOT) slot_prev[nx] = pv;
    else if (pv != NO_SLOT) tail_slot = pv;
    slot_prev[n] = NO_SLOT;
    slot_next[n] = free_slot;
    free_slot = n;
    list_len--;
    return slot_val[n];
  endfunction

  // apply one request to the shadow list and return the answer it gives
  function automatic list_answer_t run_list_op(list_req_t r);
    list_answer_t a;
    int unsigned  p, idx;
    logic [8:0]   cur;
    a.status = pdll_pkg::STS_OK;
    a.data   = '0;
    a.where  = '0;
    case (r.op)
      pdll_pkg::REQ_INS_FRONT, pdll_pkg::REQ_INS_BACK, pdll_pkg::REQ_INS_AT: begin
        if (free_slot == NO_SLOT) begin
          a.status = pdll_pkg::STS_FULL;
        end else if (list_len == 0) begin
          link_slot(0, r.value);
        end else begin
          p = (r.op == pdll_pkg::REQ_INS_FRONT) ? 0 :
              (r.op == pdll_pkg::REQ_INS_BACK) ? list_len : r.pos;
          if (p > list_len) a.status = pdll_pkg::STS_BAD_POS;
          else link_slot(p, r.value);
        end
      end
      pdll_pkg::REQ_FIND: begin
        a.status = pdll_pkg::STS_NOT_FOUND;
        cur = head_slot;
        idx = 0;
        while (cur != NO_SLOT && idx < list_len && a.status != pdll_pkg::STS_OK) begin
          if (slot_val[cur] == r.value) begin
            a.status = pdll_pkg::STS_OK;
            a.where  = 8'(idx);
          end else begin
            cur = slot_next[cur];
            idx++;
          end
        end
      end
      default: begin
        if (list_len == 0) begin
          a.status = pdll_pkg::STS_EMPTY;
        end else begin
          p = (r.op == pdll_pkg::REQ_DEL_FRONT) ? 0 :
              (r.op == pdll_pkg::REQ_DEL_BACK) ? list_len - 1 : r.pos;
          if (p >= list_len) begin
            a.status = pdll_pkg::STS_BAD_POS;
          end else if (r.op == pdll_pkg::REQ_READ_AT) begin
            cur = walk_slots(p);
            a.data = (cur != NO_SLOT) ? slot_val[cur] : '0;
          end else begin
            a.data = unlink_slot(p);
          end
        end
      end
    endcase
    a.count = 9'(list_len);
    return a;
  endfunction

  // queue a request and keep a rough count of the list length
  task automatic add_req(pdll_pkg::req_e op, int unsigned pos,
                         logic [pdll_pkg::DATA_W-1:0] v, bit drain);
    list_req_t r;
    r.op          = op;
    r.pos         = 9'(pos);
    r.value       = v;
    r.drain_first = drain;
    req_backlog.push_back(r);
    case (op)
      pdll_pkg::REQ_INS_FRONT, pdll_pkg::REQ_INS_BACK, pdll_pkg::REQ_INS_AT: begin
        if (shadow_len < POOL_SLOTS &&
            (op != pdll_pkg::REQ_INS_AT || shadow_len == 0 || pos <= shadow_len))
          shadow_len++;
      end
      pdll_pkg::REQ_DEL_FRONT, pdll_pkg::REQ_DEL_BACK, pdll_pkg::REQ_DEL_AT: begin
        if (shadow_len != 0 && (op != pdll_pkg::REQ_DEL_AT || pos < shadow_len))
          shadow_len--;
      end
      default: ;
    endcase
  endtask

  // idle percentage of each side for the current stretch of the run
  function automatic int unsigned idle_pct(bit receiver);
    if (accepted_n * 3 < total_n) return receiver ? 50 : 14;
    if (accepted_n * 3 < total_n * 2) return receiver ? 14 : 50;
    return 0;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_n++;
    end
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // request driver, one beat from the backlog at a time
  always @(negedge clk_i) begin
    list_req_t nxt_req;
    logic      offer;
    if (rst_ni) begin
      if (!req_if.valid || req_taken) begin
        offer = 1'b0;
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)
            && (!req_backlog[0].drain_first || answer_q.size() == 0)) begin
          nxt_req = req_backlog.pop_front();
          offer   = 1'b1;
          req_if.req_type    <= nxt_req.op;
          req_if.position_in <= nxt_req.pos;
          req_if.data_in     <= nxt_req.value;
        end
        req_if.valid <= offer;
      end
    end
  end

  // response ready, with one long hold-off late in the run
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && accepted_n >= hold_at) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
      end
    end
  end

  // monitor: check response beats, then predict for request beats
  always @(posedge clk_i) begin
    list_answer_t want;
    list_req_t    beat;
    if (rst_ni) begin
      req_taken <= req_if.valid && req_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        if (answer_q.size() == 0) begin
          $error("response beat with no request waiting: status %0d count %0d",
                 rsp_if.status, rsp_if.count_out);
          fail_n++;
        end else begin
          want = answer_q.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_if.status));
          check_field("data_out", want.data, rsp_if.data_out);
          check_field("position_out", 32'(want.where), 32'(rsp_if.position_out));
          check_field("count_out", 32'(want.count), 32'(rsp_if.count_out));
        end
      end
      if (req_if.valid && req_if.ready) begin
        beat.op          = pdll_pkg::req_e'(req_if.req_type);
        beat.pos         = req_if.position_in;
        beat.value       = req_if.data_in;
        beat.drain_first = 1'b0;
        answer_q.push_back(run_list_op(beat));
        accepted_n++;
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_n <= 0;
      else quiet_n <= quiet_n + 1;
    end
  end

  // watchdog on cycles without any beat
  initial begin
    while (quiet_n < QUIET_LIMIT) @(negedge clk_i);
    $display("** pooled_doubly_linked_list_core: FAILED **");
    $finish;
  end

  initial begin
    pdll_pkg::req_e ins_ops [3];
    pdll_pkg::req_e del_ops [3];
    logic [31:0]    data_edges [4];
    mix_e           mix;
    pdll_pkg::req_e op;
    int unsigned span, k, roll, pos, rand_n, ins_pct, del_pct;
    logic [31:0] val;

    ins_ops    = '{pdll_pkg::REQ_INS_FRONT, pdll_pkg::REQ_INS_BACK, pdll_pkg::REQ_INS_AT};
    del_ops    = '{pdll_pkg::REQ_DEL_FRONT, pdll_pkg::REQ_DEL_BACK, pdll_pkg::REQ_DEL_AT};
    data_edges = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000};

    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.req_type    = pdll_pkg::REQ_INS_FRONT;
    req_if.position_in = '0;
    req_if.data_in     = '0;
    rsp_if.ready       = 1'b0;
    req_taken          = 1'b0;
    accepted_n         = 0;
    quiet_n            = 0;
    fail_n             = 0;
    hold_left          = 0;
    hold_done          = 1'b0;
    shadow_len         = 0;

    // shadow pool after reset: every node free, chained in order
    for (int i = 0; i < POOL_SLOTS; i++) begin
      slot_val[i]  = '0;
      slot_next[i] = 9'(i + 1);
      slot_prev[i] = NO_SLOT;
    end
    slot_next[POOL_SLOTS-1] = NO_SLOT;
    head_slot = NO_SLOT;
    tail_slot = '0;
    free_slot = '0;
    list_len  = 0;

    // empty list: deletes and reads, find miss
    add_req(pdll_pkg::REQ_DEL_FRONT, 0, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_DEL_BACK, 256, 32'hffff_ffff, 1'b0);
    add_req(pdll_pkg::REQ_DEL_AT, 0, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_READ_AT, 0, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_FIND, 0, 32'h0, 1'b0);
    // insert into empty list ignores the position
    add_req(pdll_pkg::REQ_INS_AT, 256, 32'h7fff_ffff, 1'b0);
    add_req(pdll_pkg::REQ_INS_AT, 2, 32'h1234_5678, 1'b0);
    add_req(pdll_pkg::REQ_INS_AT, 1, 32'h8000_0000, 1'b0);
    add_req(pdll_pkg::REQ_INS_FRONT, 255, 32'hffff_ffff, 1'b0);
    add_req(pdll_pkg::REQ_INS_BACK, 0, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_INS_AT, 0, 32'h5555_aaaa, 1'b0);
    add_req(pdll_pkg::REQ_INS_AT, 2, 32'haaaa_5555, 1'b0);
    // reads, finds and deletes at the edges
    add_req(pdll_pkg::REQ_READ_AT, 5, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_READ_AT, 6, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_READ_AT, 256, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_FIND, 0, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_FIND, 0, 32'haaaa_5555, 1'b0);
    add_req(pdll_pkg::REQ_FIND, 0, 32'h1234_5678, 1'b0);
    add_req(pdll_pkg::REQ_DEL_AT, 6, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_DEL_AT, 2, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_DEL_BACK, 0, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_DEL_FRONT, 0, 32'h0, 1'b0);
    add_req(pdll_pkg::REQ_DEL_AT, 1, 32'h0, 1'b0);

    // random stretches: first fill the pool past full, then drain it, then random mixes
    rand_n = 0;
    for (int ep = 0; rand_n < RANDOM_REQS; ep++) begin
      if (ep == 0) begin
        mix  = MIX_GROW;
        span = 380;
      end else if (ep == 1) begin
        mix  = MIX_SHRINK;
        span = 320;
      end else begin
        mix  = mix_e'($urandom_range(0, 2));
        span = $urandom_range(100, 300);
      end
      ins_pct = (mix == MIX_GROW) ? 90 : (mix == MIX_SHRINK) ? 5 : 40;
      del_pct = (mix == MIX_GROW) ? 5 : (mix == MIX_SHRINK) ? 90 : 35;
      for (k = 0; k < span; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) op = ins_ops[$urandom_range(0, 2)];
        else if (roll < ins_pct + del_pct) op = del_ops[$urandom_range(0, 2)];
        else op = $urandom_range(0, 1) ? pdll_pkg::REQ_FIND : pdll_pkg::REQ_READ_AT;
        // mostly positions inside the list
        pos = $urandom_range(0, 256);
        if ($urandom_range(0, 99) < 85) begin
          if (op == pdll_pkg::REQ_INS_AT) pos = $urandom_range(0, shadow_len);
          else if ((op == pdll_pkg::REQ_DEL_AT || op == pdll_pkg::REQ_READ_AT) &&
                   shadow_len != 0)
            pos = $urandom_range(0, shadow_len - 1);
        end
        // small values repeat so finds hit
        roll = $urandom_range(0, 99);
        if (roll < 50) val = $urandom_range(0, 15);
        else if (roll < 58) val = data_edges[$urandom_range(0, 3)];
        else val = $urandom;
        add_req(op, pos, val, k == 0);
      end
      rand_n += span;
    end

    total_n = req_backlog.size();
    hold_at = total_n * 5 / 6;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for the backlog to go out and every answer to come back
    while (req_backlog.size() != 0 || req_if.valid || answer_q.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (fail_n == 0 && answer_q.size() == 0) begin
      $display("** pooled_doubly_linked_list_core: PASSED **");
    end else begin
      $display("** pooled_doubly_linked_list_core: FAILED **");
    end
    $finish;
  end

endmodule
